>>> hw/rtl/ncomix_pkg.sv
// Shared types, constants and the sine table generator for the NCO complex mixer.
// Used by ncomix_phasor, ncomix_rotator and nco_complex_mixer_unit; no dependencies.
`timescale 1ns / 1ps

package ncomix_pkg;

  // Phasor samples are Q1.15 signed words.
  localparam int unsigned TrigBits = 16;
  localparam int unsigned FracBits = 15;
  localparam int unsigned TrigMax  = 32767;

  // Width of the configuration write data (the phase step register).
  localparam int unsigned CfgBits = 32;

  // 2*pi in Q30 and the number of Taylor series terms used for the table.
  localparam logic [63:0] TwoPiQ30    = 64'd6746518852;
  localparam int unsigned TaylorTerms = 8;

  // Pipeline control shared by the phasor and rotator stages.
  typedef struct packed {
    logic accept;   // an input item enters the pipeline this cycle
    logic advance;  // every pipeline stage loads this cycle
  } pipe_ctrl_t;

  // Quarter-wave sine table entry k for a table of 2^addr_bits points per
  // circle. Evaluated at elaboration only: a Q30 Taylor series of sin(x),
  // then scaled to 32767 with round half up and clamped to 0..32767.
  function automatic logic [TrigBits-2:0] sine_entry(int unsigned addr_bits, int unsigned k);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        v;
    x    = (64'(k) * TwoPiQ30 + (64'd1 << (addr_bits - 1))) >> addr_bits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = signed'(x);
    for (int n = 1; n <= TaylorTerms; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if ((n & 1) != 0) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    v = (64'(unsigned'(sum)) * 64'(TrigMax) + (64'd1 << 29)) >> 30;
    if (v > 64'(TrigMax)) begin
      v = 64'(TrigMax);
    end
    return v[TrigBits-2:0];
  endfunction

endpackage

>>> hw/rtl/ncomix_phasor.sv
// Phase accumulator and quarter-wave sine/cosine lookup of the NCO complex mixer.
// Depends on ncomix_pkg for the table generator, widths and pipeline control struct.
`timescale 1ns / 1ps

module ncomix_phasor #(
  parameter int unsigned PHASE_BITS      = 32,
  parameter int unsigned TABLE_ADDR_BITS = 10
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  ncomix_pkg::pipe_ctrl_t                   ctrl_i,
  input  logic [ncomix_pkg::CfgBits-1:0]           step_i,
  output logic signed [ncomix_pkg::TrigBits-1:0]   sin_o,
  output logic signed [ncomix_pkg::TrigBits-1:0]   cos_o
);

  localparam int unsigned QuarterLen = 2 ** (TABLE_ADDR_BITS - 2);
  localparam int unsigned IdxBits    = TABLE_ADDR_BITS - 1;

  logic [PHASE_BITS-1:0]               acc_q;
  logic [PHASE_BITS-1:0]               acc_d;
  logic [TABLE_ADDR_BITS-1:0]          sin_addr;
  logic [TABLE_ADDR_BITS-1:0]          cos_addr;
  logic [ncomix_pkg::TrigBits-2:0]     rom [QuarterLen+1];
  logic [ncomix_pkg::TrigBits-2:0]     sin_mag;
  logic [ncomix_pkg::TrigBits-2:0]     cos_mag;
  logic signed [ncomix_pkg::TrigBits-1:0] sin_d;
  logic signed [ncomix_pkg::TrigBits-1:0] cos_d;
  logic signed [ncomix_pkg::TrigBits-1:0] sin_q;
  logic signed [ncomix_pkg::TrigBits-1:0] cos_q;

  // Constant quarter-wave table, built at elaboration.
  for (genvar k = 0; k <= QuarterLen; k++) begin : g_rom
    assign rom[k] = ncomix_pkg::sine_entry(TABLE_ADDR_BITS, k);
  end

  // Table index for a full-circle address: odd quadrants run the table backward.
  function automatic logic [IdxBits-1:0] table_idx(logic [TABLE_ADDR_BITS-1:0] a);
    logic [TABLE_ADDR_BITS-3:0] r;
    r = a[TABLE_ADDR_BITS-3:0];
    if (a[TABLE_ADDR_BITS-2]) begin
      return IdxBits'(QuarterLen) - IdxBits'(r);
    end
    return IdxBits'(r);
  endfunction

  // The accumulator steps once per accepted item, wrapping at the full circle.
  assign acc_d = acc_q + PHASE_BITS'(step_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctrl_i.accept) begin
      acc_q <= acc_d;
    end
  end

  // Cosine is the sine a quarter circle ahead.
  assign sin_addr = acc_q[PHASE_BITS-1 -: TABLE_ADDR_BITS];
  assign cos_addr = sin_addr + TABLE_ADDR_BITS'(QuarterLen);

  // Look up magnitudes and apply the sign of the lower half circle.
  always_comb begin
    sin_mag = rom[table_idx(sin_addr)];
    cos_mag = rom[table_idx(cos_addr)];
    sin_d   = sin_addr[TABLE_ADDR_BITS-1] ? -signed'({1'b0, sin_mag}) : signed'({1'b0, sin_mag});
    cos_d   = cos_addr[TABLE_ADDR_BITS-1] ? -signed'({1'b0, cos_mag}) : signed'({1'b0, cos_mag});
  end

  // Phasor register, aligned with the delayed sample.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.advance) begin
      sin_q <= sin_d;
      cos_q <= cos_d;
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

>>> hw/rtl/ncomix_rotator.sv
// Complex multiply of the sample by the phasor, with rounding and saturation.
// Depends on ncomix_pkg for the phasor width, fraction bits and pipeline control struct.
`timescale 1ns / 1ps

module ncomix_rotator #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                                   clk_i,
  input  ncomix_pkg::pipe_ctrl_t                 ctrl_i,
  input  logic signed [SAMPLE_BITS-1:0]          in_i_i,
  input  logic signed [SAMPLE_BITS-1:0]          in_q_i,
  input  logic signed [ncomix_pkg::TrigBits-1:0] sin_i,
  input  logic signed [ncomix_pkg::TrigBits-1:0] cos_i,
  output logic signed [SAMPLE_BITS-1:0]          out_i_o,
  output logic signed [SAMPLE_BITS-1:0]          out_q_o
);

  localparam int unsigned ProdBits  = SAMPLE_BITS + ncomix_pkg::TrigBits;
  localparam int unsigned SumBits   = ProdBits + 1;
  localparam int unsigned ShiftBits = SumBits - ncomix_pkg::FracBits;

  localparam logic signed [ShiftBits-1:0] SatMax = ShiftBits'((2 ** (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [ShiftBits-1:0] SatMin = -SatMax - ShiftBits'(1);
  localparam logic signed [SumBits-1:0]   Half   = SumBits'(2 ** (ncomix_pkg::FracBits - 1));

  logic signed [SAMPLE_BITS-1:0] s1_i_q;
  logic signed [SAMPLE_BITS-1:0] s1_q_q;
  logic signed [SAMPLE_BITS-1:0] s2_i_q;
  logic signed [SAMPLE_BITS-1:0] s2_q_q;
  logic signed [ProdBits-1:0]    ic_q;
  logic signed [ProdBits-1:0]    qs_q;
  logic signed [ProdBits-1:0]    is_q;
  logic signed [ProdBits-1:0]    qc_q;
  logic signed [SAMPLE_BITS-1:0] out_i_d;
  logic signed [SAMPLE_BITS-1:0] out_q_d;
  logic signed [SAMPLE_BITS-1:0] out_i_q;
  logic signed [SAMPLE_BITS-1:0] out_q_q;

  // Round half up (add half an LSB, floor shift) and clamp to the sample range.
  function automatic logic signed [SAMPLE_BITS-1:0] round_sat(logic signed [SumBits-1:0] acc);
    logic signed [SumBits-1:0]   biased;
    logic signed [ShiftBits-1:0] r;
    biased = acc + Half;
    r      = biased[SumBits-1:ncomix_pkg::FracBits];
    if (r > SatMax) begin
      r = SatMax;
    end else if (r < SatMin) begin
      r = SatMin;
    end
    return r[SAMPLE_BITS-1:0];
  endfunction

  // Sample delay line: input register, then alignment with the phasor register.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.advance) begin
      s1_i_q <= in_i_i;
      s1_q_q <= in_q_i;
      s2_i_q <= s1_i_q;
      s2_q_q <= s1_q_q;
    end
  end

  // Four partial products, registered before the sums.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.advance) begin
      ic_q <= ProdBits'(s2_i_q * cos_i);
      qs_q <= ProdBits'(s2_q_q * sin_i);
      is_q <= ProdBits'(s2_i_q * sin_i);
      qc_q <= ProdBits'(s2_q_q * cos_i);
    end
  end

  // Real and imaginary sums of the complex product.
  always_comb begin
    out_i_d = round_sat(SumBits'(ic_q) - SumBits'(qs_q));
    out_q_d = round_sat(SumBits'(is_q) + SumBits'(qc_q));
  end

  // Result register; holds while the consumer stalls.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.advance) begin
      out_i_q <= out_i_d;
      out_q_q <= out_q_d;
    end
  end

  assign out_i_o = out_i_q;
  assign out_q_o = out_q_q;

endmodule

>>> hw/rtl/nco_complex_mixer_unit.sv
// NCO complex mixer: rotates each complex item by a phasor that advances by the phase step.
// A result passes the input register, the phasor lookup register, the product register
// and the result register after its item is accepted. Throughput: one item per
// cycle; the whole pipeline holds only while a presented result is stalled.
// Reset clears the phase accumulator, the phase step and all valid flags.
// Depends on ncomix_pkg, ncomix_phasor and ncomix_rotator.
`timescale 1ns / 1ps

module nco_complex_mixer_unit #(
  parameter int unsigned SAMPLE_BITS     = 16,
  parameter int unsigned PHASE_BITS      = 32,
  parameter int unsigned TABLE_ADDR_BITS = 10
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration write channel (phase step)
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [ncomix_pkg::CfgBits-1:0]       cfg_data_i,
  // Input item channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]        in_i_i,
  input  logic signed [SAMPLE_BITS-1:0]        in_q_i,
  // Result item channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]        out_i_o,
  output logic signed [SAMPLE_BITS-1:0]        out_q_o
);

  logic                                   advance;
  ncomix_pkg::pipe_ctrl_t                 ctrl;
  logic [ncomix_pkg::CfgBits-1:0]         step_q;
  logic                                   v1_q;
  logic                                   v2_q;
  logic                                   v3_q;
  logic                                   out_valid_q;
  logic signed [ncomix_pkg::TrigBits-1:0] sin_w;
  logic signed [ncomix_pkg::TrigBits-1:0] cos_w;

  // The pipeline moves unless a presented result is being held.
  assign advance      = !(out_valid_q && out_stall_i);
  assign ctrl.advance = advance;
  assign ctrl.accept  = in_valid_i && advance;
  assign in_stall_o   = !advance;

  // Phase step register; writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (cfg_valid_i) begin
      step_q <= cfg_data_i;
    end
  end

  // Valid flags travel alongside the payload stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      v1_q        <= in_valid_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      out_valid_q <= v3_q;
    end
  end

  assign out_valid_o = out_valid_q;

  ncomix_phasor #(
    .PHASE_BITS      (PHASE_BITS),
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
  ) u_phasor (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .step_i (step_q),
    .sin_o  (sin_w),
    .cos_o  (cos_w)
  );

  ncomix_rotator #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_rotator (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .in_i_i  (in_i_i),
    .in_q_i  (in_q_i),
    .sin_i   (sin_w),
    .cos_i   (cos_w),
    .out_i_o (out_i_o),
    .out_q_o (out_q_o)
  );

  // The input side is only held back while a presented result is stalled.
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  // An accepted item occupies the first stage on the next cycle.
  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> v1_q)
    else $error("accepted item missing from first stage");

  // When the pipeline moves, the result flag follows the last stage.
  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |=> (out_valid_o == $past(v3_q)))
    else $error("result valid out of step with the pipeline");

endmodule
